FILE: design/aarm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared types, constants and fixed-point helpers of the axis-angle
// rotation matrix pipeline.
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam int COEF_FRAC_BITS  = 14;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int IQ              = 30;
    localparam int OUT_SHIFT       = IQ - COEF_FRAC_BITS;

    // angle constants in input units
    localparam int ANG_FULL = 360 << ANGLE_FRAC_BITS;
    localparam int ANG_Q90  = 90 << ANGLE_FRAC_BITS;
    localparam int ANG_Q45  = 45 << ANGLE_FRAC_BITS;
    localparam int DEG_SHIFT = ANGLE_FRAC_BITS + 10;

    localparam logic [34:0] DEG2RAD_Q40 = 35'd19190098069;

    // unit axis and angle, after normalization
    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               zero;
    } aarm_axis_t;

    // unit axis with sine and cosine, Q30
    typedef struct packed {
        logic signed [32:0] s;
        logic signed [32:0] c;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               zero;
    } aarm_trig_t;

    // Q30 product, magnitude truncated toward zero
    function automatic logic signed [38:0] qmul(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic [33:0] ma;
        logic [33:0] mb;
        logic [67:0] pr;
        logic [37:0] m;
        ma = a[33] ? 34'(-a) : 34'(a);
        mb = b[33] ? 34'(-b) : 34'(b);
        pr = 68'(ma) * 68'(mb);
        m  = pr[67:30];
        return (a[33] ^ b[33]) ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    // round half away from zero to the output format, then saturate
    function automatic logic [15:0] to_out(input logic signed [39:0] v);
        logic [39:0] mag;
        logic [39:0] r;
        logic [15:0] res;
        mag = v[39] ? 40'(-v) : 40'(v);
        r   = (mag + (40'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        if (v[39]) begin
            res = (r > 40'd32768) ? 16'h8000 : 16'(-r);
        end else begin
            res = (r > 40'd32767) ? 16'h7fff : r[15:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: design/aarm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_in_if
// Input channel: angle and raw axis, valid/ready.
// ----------------------------------------------------------------------------
interface aarm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle_deg;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;

    modport source (output valid, output angle_deg, output axis_x, output axis_y,
                    output axis_z, input ready);
    modport sink   (input valid, input angle_deg, input axis_x, input axis_y,
                    input axis_z, output ready);
endinterface
`default_nettype wire

FILE: design/aarm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_out_if
// Output channel: 3x3 matrix entries and zero-axis flag, valid/ready.
// ----------------------------------------------------------------------------
interface aarm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               zero_axis;

    modport source (output valid, output m00, output m01, output m02, output m10,
                    output m11, output m12, output m20, output m21, output m22,
                    output zero_axis, input ready);
    modport sink   (input valid, input m00, input m01, input m02, input m10,
                    input m11, input m12, input m20, input m21, input m22,
                    input zero_axis, output ready);
endinterface
`default_nettype wire

FILE: design/axis_angle_rotation_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Rotation matrix from an angle in degrees and an arbitrary axis, fixed point.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_ch     in   angle_deg, axis_x, axis_y, axis_z
//  out_ch    out  m00..m22, zero_axis
//
//  One transfer per cycle in and out while the output is not stalled. The
//  pipeline runs normalize, sine/cosine, matrix; the bit-per-stage square
//  root and divider make the normalizer its longest part. Every stage has
//  its own valid bit and moves when empty or when the stage after it moves, so
//  bubbles close up under a stalled output. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix (
    input  logic         clk,
    input  logic         rst_n,
    aarm_in_if.sink      in_ch,
    aarm_out_if.source   out_ch
);

    logic                 nrm_valid;
    logic                 nrm_ready;
    aarm_pkg::aarm_axis_t nrm_data;
    logic                 trg_valid;
    logic                 trg_ready;
    aarm_pkg::aarm_trig_t trg_data;
    logic [8:0][15:0]     mat;
    logic                 zero;

    aarm_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .angle     (in_ch.angle_deg),
        .ax        (in_ch.axis_x),
        .ay        (in_ch.axis_y),
        .az        (in_ch.axis_z),
        .out_valid (nrm_valid),
        .out_ready (nrm_ready),
        .out_data  (nrm_data)
    );

    aarm_sincos u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (nrm_valid),
        .in_ready  (nrm_ready),
        .in_data   (nrm_data),
        .out_valid (trg_valid),
        .out_ready (trg_ready),
        .out_data  (trg_data)
    );

    aarm_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trg_valid),
        .in_ready  (trg_ready),
        .in_data   (trg_data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .mat       (mat),
        .zero      (zero)
    );

    assign out_ch.m00       = $signed(mat[0]);
    assign out_ch.m01       = $signed(mat[1]);
    assign out_ch.m02       = $signed(mat[2]);
    assign out_ch.m10       = $signed(mat[3]);
    assign out_ch.m11       = $signed(mat[4]);
    assign out_ch.m12       = $signed(mat[5]);
    assign out_ch.m20       = $signed(mat[6]);
    assign out_ch.m21       = $signed(mat[7]);
    assign out_ch.m22       = $signed(mat[8]);
    assign out_ch.zero_axis = zero;

endmodule
`default_nettype wire

FILE: design/aarm_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_norm
// Axis normalization: sum of squares, even pre-shift, bit-per-stage square
// root, then three bit-per-stage divisions by the root and a clamp to 1.0.
// ----------------------------------------------------------------------------
module aarm_norm (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [15:0]        angle,
    input  logic signed [15:0]        ax,
    input  logic signed [15:0]        ay,
    input  logic signed [15:0]        az,
    output logic                      out_valid,
    input  logic                      out_ready,
    output aarm_pkg::aarm_axis_t      out_data
);

    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = 31;
    localparam int SQ_FIRST  = 3;
    localparam int DIV_FIRST = SQ_FIRST + SQ_STEPS;
    localparam int NS        = DIV_FIRST + DIV_STEPS + 1;

    typedef struct packed {
        logic signed [15:0] angle;
        logic               zero;
        logic [2:0]         neg;
        logic [2:0][15:0]   mag;
        logic [4:0]         e;
        logic [62:0]        v;
        logic [62:0]        res;
        logic [2:0][31:0]   rem;
        logic [2:0][30:0]   dlo;
        logic [2:0][30:0]   quo;
    } norm_st_t;

    norm_st_t        st_reg  [NS];
    norm_st_t        st_next [NS];
    logic [NS-1:0]   vld_reg;
    logic [NS:0]     adv;

    assign adv[NS]  = out_ready;
    assign in_ready = adv[0];

    for (genvar i = 0; i < NS; i++) begin : g_st
        assign adv[i] = ~vld_reg[i] | adv[i+1];

        if (i == 0) begin : g_sq
            always_comb
            begin
                logic signed [15:0] a [3];
                logic [31:0]        sq [3];
                logic [33:0]        n2;
                a[0] = ax;
                a[1] = ay;
                a[2] = az;
                st_next[i] = '0;
                st_next[i].angle = angle;
                for (int c = 0; c < 3; c++) begin
                    st_next[i].neg[c] = a[c][15];
                    st_next[i].mag[c] = a[c][15] ? 16'(-a[c]) : 16'(a[c]);
                    sq[c] = st_next[i].mag[c] * st_next[i].mag[c];
                end
                n2 = {2'b0, sq[0]} + {2'b0, sq[1]} + {2'b0, sq[2]};
                st_next[i].v = 63'(n2);
            end
        end else if (i == 1) begin : g_lz
            // even shift so that the shifted norm lands in [2^60, 2^62)
            always_comb
            begin
                logic [5:0] p;
                p = '0;
                st_next[i] = st_reg[i-1];
                for (int b = 0; b < 34; b++) begin
                    if (st_reg[i-1].v[b]) begin
                        p = 6'(b);
                    end
                end
                st_next[i].zero = (st_reg[i-1].v == '0);
                st_next[i].e    = 5'((7'd61 - 7'(p)) >> 1);
            end
        end else if (i == 2) begin : g_sh
            always_comb
            begin
                logic [75:0] d;
                st_next[i] = st_reg[i-1];
                st_next[i].v   = st_reg[i-1].v << {st_reg[i-1].e, 1'b0};
                st_next[i].res = '0;
                for (int c = 0; c < 3; c++) begin
                    d = 76'(st_reg[i-1].mag[c]) << (7'd30 + 7'(st_reg[i-1].e));
                    st_next[i].rem[c] = d[62:31];
                    st_next[i].dlo[c] = d[30:0];
                end
            end
        end else if (i < DIV_FIRST) begin : g_sqrt
            localparam int K = DIV_FIRST - 1 - i;
            always_comb
            begin
                logic [62:0] bitv;
                logic [62:0] trial;
                bitv  = 63'(1) << (2 * K);
                trial = st_reg[i-1].res + bitv;
                st_next[i] = st_reg[i-1];
                if (st_reg[i-1].v >= trial) begin
                    st_next[i].v   = st_reg[i-1].v - trial;
                    st_next[i].res = (st_reg[i-1].res >> 1) + bitv;
                end else begin
                    st_next[i].res = st_reg[i-1].res >> 1;
                end
            end
        end else if (i < NS - 1) begin : g_div
            always_comb
            begin
                logic [31:0] r2;
                logic [31:0] root;
                root = {1'b0, st_reg[i-1].res[30:0]};
                st_next[i] = st_reg[i-1];
                for (int c = 0; c < 3; c++) begin
                    r2 = {st_reg[i-1].rem[c][30:0], st_reg[i-1].dlo[c][30]};
                    st_next[i].dlo[c] = st_reg[i-1].dlo[c] << 1;
                    if (r2 >= root) begin
                        st_next[i].rem[c] = r2 - root;
                        st_next[i].quo[c] = {st_reg[i-1].quo[c][29:0], 1'b1};
                    end else begin
                        st_next[i].rem[c] = r2;
                        st_next[i].quo[c] = {st_reg[i-1].quo[c][29:0], 1'b0};
                    end
                end
            end
        end else begin : g_clamp
            always_comb
            begin
                st_next[i] = st_reg[i-1];
                for (int c = 0; c < 3; c++) begin
                    if (st_reg[i-1].quo[c] > (31'd1 << 30)) begin
                        st_next[i].quo[c] = 31'd1 << 30;
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                vld_reg[i] <= 1'b0;
            end else if (adv[i]) begin
                vld_reg[i] <= (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[i]) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_comb
    begin
        logic signed [31:0] u [3];
        for (int c = 0; c < 3; c++) begin
            u[c] = st_reg[NS-1].neg[c] ? -$signed({1'b0, st_reg[NS-1].quo[c]})
                                       : $signed({1'b0, st_reg[NS-1].quo[c]});
        end
        out_data.angle = st_reg[NS-1].angle;
        out_data.x     = u[0];
        out_data.y     = u[1];
        out_data.z     = u[2];
        out_data.zero  = st_reg[NS-1].zero;
    end

    assign out_valid = vld_reg[NS-1];

endmodule
`default_nettype wire

FILE: design/aarm_sincos.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_sincos
// Angle reduction to one octant, degree-to-radian scaling and a pipelined
// Taylor series for sine and cosine, followed by quadrant unfolding.
// ----------------------------------------------------------------------------
module aarm_sincos (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aarm_pkg::aarm_axis_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aarm_pkg::aarm_trig_t out_data
);

    localparam int TERMS  = 6;
    localparam int T_BASE = 4;
    localparam int NS     = T_BASE + 3 * TERMS + 1;

    typedef struct packed {
        aarm_pkg::aarm_axis_t ax;
        logic [14:0]          r;
        logic [1:0]           quad;
        logic                 swap;
        logic [11:0]          u;
        logic [30:0]          x;
        logic [30:0]          x2;
        logic [30:0]          ts;
        logic [30:0]          tc;
        logic [30:0]          ns;
        logic [30:0]          nc;
        logic [30:0]          qs;
        logic [30:0]          qc;
        logic signed [32:0]   s0;
        logic signed [32:0]   c0;
    } sc_st_t;

    sc_st_t          st_reg  [NS];
    sc_st_t          st_next [NS];
    logic [NS-1:0]   vld_reg;
    logic [NS:0]     adv;

    assign adv[NS]  = out_ready;
    assign in_ready = adv[0];

    for (genvar i = 0; i < NS; i++) begin : g_st
        assign adv[i] = ~vld_reg[i] | adv[i+1];

        if (i == 0) begin : g_mod
            // angle mod 360 into [0, 360)
            always_comb
            begin
                logic [17:0] t;
                t = 18'({{2{in_data.angle[15]}}, in_data.angle}) + 18'(2 * aarm_pkg::ANG_FULL);
                for (int k = 0; k < 3; k++) begin
                    if (t >= 18'(aarm_pkg::ANG_FULL)) begin
                        t = t - 18'(aarm_pkg::ANG_FULL);
                    end
                end
                st_next[i] = '0;
                st_next[i].ax = in_data;
                st_next[i].r  = t[14:0];
            end
        end else if (i == 1) begin : g_fold
            always_comb
            begin
                logic [14:0] rem;
                st_next[i] = st_reg[i-1];
                if (st_reg[i-1].r >= 15'(3 * aarm_pkg::ANG_Q90)) begin
                    st_next[i].quad = 2'd3;
                    rem = st_reg[i-1].r - 15'(3 * aarm_pkg::ANG_Q90);
                end else if (st_reg[i-1].r >= 15'(2 * aarm_pkg::ANG_Q90)) begin
                    st_next[i].quad = 2'd2;
                    rem = st_reg[i-1].r - 15'(2 * aarm_pkg::ANG_Q90);
                end else if (st_reg[i-1].r >= 15'(aarm_pkg::ANG_Q90)) begin
                    st_next[i].quad = 2'd1;
                    rem = st_reg[i-1].r - 15'(aarm_pkg::ANG_Q90);
                end else begin
                    st_next[i].quad = 2'd0;
                    rem = st_reg[i-1].r;
                end
                st_next[i].swap = (rem > 15'(aarm_pkg::ANG_Q45));
                st_next[i].u    = st_next[i].swap ? 12'(15'(aarm_pkg::ANG_Q90) - rem)
                                                  : 12'(rem);
            end
        end else if (i == 2) begin : g_rad
            always_comb
            begin
                logic [46:0] px;
                px = 47'(st_reg[i-1].u) * 47'(aarm_pkg::DEG2RAD_Q40);
                st_next[i] = st_reg[i-1];
                st_next[i].x = 31'(px >> aarm_pkg::DEG_SHIFT);
            end
        end else if (i == 3) begin : g_sq
            always_comb
            begin
                logic [61:0] p2;
                p2 = 62'(st_reg[i-1].x) * 62'(st_reg[i-1].x);
                st_next[i] = st_reg[i-1];
                st_next[i].x2 = p2[60:30];
                st_next[i].ts = st_reg[i-1].x;
                st_next[i].tc = 31'd1 << 30;
                st_next[i].s0 = $signed({2'b0, st_reg[i-1].x});
                st_next[i].c0 = 33'sd1 <<< 30;
            end
        end else if (i < NS - 1) begin : g_term
            localparam int K  = (i - T_BASE) / 3 + 1;
            localparam int PH = (i - T_BASE) % 3;
            localparam int DS = (2 * K) * (2 * K + 1);
            localparam int DC = (2 * K - 1) * (2 * K);
            localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
            localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);
            localparam bit ODD = (K % 2) == 1;
            if (PH == 0) begin : g_mul
                always_comb
                begin
                    logic [61:0] ps;
                    logic [61:0] pc;
                    ps = 62'(st_reg[i-1].ts) * 62'(st_reg[i-1].x2);
                    pc = 62'(st_reg[i-1].tc) * 62'(st_reg[i-1].x2);
                    st_next[i] = st_reg[i-1];
                    st_next[i].ns = ps[60:30];
                    st_next[i].nc = pc[60:30];
                end
            end else if (PH == 1) begin : g_rcp
                // quotient estimate by reciprocal, low by at most one
                always_comb
                begin
                    logic [62:0] ps;
                    logic [62:0] pc;
                    ps = 63'(st_reg[i-1].ns) * 63'(MS);
                    pc = 63'(st_reg[i-1].nc) * 63'(MC);
                    st_next[i] = st_reg[i-1];
                    st_next[i].qs = ps[62:32];
                    st_next[i].qc = pc[62:32];
                end
            end else begin : g_fix
                always_comb
                begin
                    logic [38:0] rs;
                    logic [38:0] rc;
                    logic [30:0] qs;
                    logic [30:0] qc;
                    rs = 39'(st_reg[i-1].ns) - 39'(st_reg[i-1].qs) * 39'(DS);
                    rc = 39'(st_reg[i-1].nc) - 39'(st_reg[i-1].qc) * 39'(DC);
                    qs = (rs >= 39'(DS)) ? st_reg[i-1].qs + 31'd1 : st_reg[i-1].qs;
                    qc = (rc >= 39'(DC)) ? st_reg[i-1].qc + 31'd1 : st_reg[i-1].qc;
                    st_next[i] = st_reg[i-1];
                    st_next[i].ts = qs;
                    st_next[i].tc = qc;
                    if (ODD) begin
                        st_next[i].s0 = st_reg[i-1].s0 - $signed({2'b0, qs});
                        st_next[i].c0 = st_reg[i-1].c0 - $signed({2'b0, qc});
                    end else begin
                        st_next[i].s0 = st_reg[i-1].s0 + $signed({2'b0, qs});
                        st_next[i].c0 = st_reg[i-1].c0 + $signed({2'b0, qc});
                    end
                end
            end
        end else begin : g_quad
            always_comb
            begin
                logic signed [32:0] ts;
                logic signed [32:0] tc;
                ts = st_reg[i-1].swap ? st_reg[i-1].c0 : st_reg[i-1].s0;
                tc = st_reg[i-1].swap ? st_reg[i-1].s0 : st_reg[i-1].c0;
                st_next[i] = st_reg[i-1];
                case (st_reg[i-1].quad)
                    2'd0: begin
                        st_next[i].s0 = ts;
                        st_next[i].c0 = tc;
                    end
                    2'd1: begin
                        st_next[i].s0 = tc;
                        st_next[i].c0 = -ts;
                    end
                    2'd2: begin
                        st_next[i].s0 = -ts;
                        st_next[i].c0 = -tc;
                    end
                    default: begin
                        st_next[i].s0 = -tc;
                        st_next[i].c0 = ts;
                    end
                endcase
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                vld_reg[i] <= 1'b0;
            end else if (adv[i]) begin
                vld_reg[i] <= (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[i]) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_data.s    = st_reg[NS-1].s0;
    assign out_data.c    = st_reg[NS-1].c0;
    assign out_data.x    = st_reg[NS-1].ax.x;
    assign out_data.y    = st_reg[NS-1].ax.y;
    assign out_data.z    = st_reg[NS-1].ax.z;
    assign out_data.zero = st_reg[NS-1].ax.zero;
    assign out_valid     = vld_reg[NS-1];

endmodule
`default_nettype wire

FILE: design/aarm_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_matrix
// Axis products, (1 - c) scaling, entry sums and output rounding, with the identity for a zero axis.
// ----------------------------------------------------------------------------
module aarm_matrix (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aarm_pkg::aarm_trig_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [8:0][15:0]     mat,
    output logic                 zero
);

    localparam int NS = 3;

    typedef struct packed {
        logic               zero;
        logic signed [32:0] c;
        logic signed [33:0] omc;
        logic [2:0][38:0]   sv;
        logic [5:0][38:0]   p;
        logic [8:0][15:0]   m;
    } mx_st_t;

    mx_st_t          st_reg  [NS];
    mx_st_t          st_next [NS];
    logic [NS-1:0]   vld_reg;
    logic [NS:0]     adv;

    assign adv[NS]  = out_ready;
    assign in_ready = adv[0];

    // stage 0: sine terms and symmetric axis products (xx xy xz yy yz zz)
    always_comb
    begin
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic signed [33:0] s;
        x = 34'(in_data.x);
        y = 34'(in_data.y);
        z = 34'(in_data.z);
        s = 34'(in_data.s);
        st_next[0]       = '0;
        st_next[0].zero  = in_data.zero;
        st_next[0].c     = in_data.c;
        st_next[0].omc   = (34'sd1 <<< aarm_pkg::IQ) - 34'(in_data.c);
        st_next[0].sv[0] = aarm_pkg::qmul(x, s);
        st_next[0].sv[1] = aarm_pkg::qmul(y, s);
        st_next[0].sv[2] = aarm_pkg::qmul(z, s);
        st_next[0].p[0]  = aarm_pkg::qmul(x, x);
        st_next[0].p[1]  = aarm_pkg::qmul(x, y);
        st_next[0].p[2]  = aarm_pkg::qmul(x, z);
        st_next[0].p[3]  = aarm_pkg::qmul(y, y);
        st_next[0].p[4]  = aarm_pkg::qmul(y, z);
        st_next[0].p[5]  = aarm_pkg::qmul(z, z);
    end

    always_comb
    begin
        st_next[1] = st_reg[0];
        for (int j = 0; j < 6; j++) begin
            st_next[1].p[j] = aarm_pkg::qmul(34'($signed(st_reg[0].p[j])), st_reg[0].omc);
        end
    end

    always_comb
    begin
        logic signed [39:0] c;
        logic signed [39:0] t [6];
        logic signed [39:0] sx;
        logic signed [39:0] sy;
        logic signed [39:0] sz;
        logic signed [39:0] e [9];
        c  = 40'(st_reg[1].c);
        sx = 40'($signed(st_reg[1].sv[0]));
        sy = 40'($signed(st_reg[1].sv[1]));
        sz = 40'($signed(st_reg[1].sv[2]));
        for (int j = 0; j < 6; j++) begin
            t[j] = 40'($signed(st_reg[1].p[j]));
        end
        // sine terms follow the transposed cross-product placement
        e[0] = c + t[0];
        e[1] = t[1] + sz;
        e[2] = t[2] - sy;
        e[3] = t[1] - sz;
        e[4] = c + t[3];
        e[5] = t[4] + sx;
        e[6] = t[2] + sy;
        e[7] = t[4] - sx;
        e[8] = c + t[5];
        st_next[2] = st_reg[1];
        for (int j = 0; j < 9; j++) begin
            if (st_reg[1].zero) begin
                st_next[2].m[j] = (j % 4 == 0) ? aarm_pkg::to_out(40'sd1 <<< aarm_pkg::IQ)
                                               : 16'd0;
            end else begin
                st_next[2].m[j] = aarm_pkg::to_out(e[j]);
            end
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_st
        assign adv[i] = ~vld_reg[i] | adv[i+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                vld_reg[i] <= 1'b0;
            end else if (adv[i]) begin
                vld_reg[i] <= (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[i]) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign mat       = st_reg[NS-1].m;
    assign zero      = st_reg[NS-1].zero;
    assign out_valid = vld_reg[NS-1];

endmodule
`default_nettype wire
